[hdl/ctbd_pkg.sv]
// Shared types, codes and the 5-to-8 bit channel table for the 4x4 texel block decoder.
// No dependencies.
package ctbd_pkg;

  localparam int PALETTE_DEPTH = 4096;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int CFG_DW        = 13;
  localparam int CFG_IW        = 2;

  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_DECODE    = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PAL_ENTRIES = 2'd2;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_MID    = 2'd1,
    MODE_FOUR   = 2'd2,
    MODE_BLEND  = 2'd3
  } mode_t;

  typedef struct packed {
    logic        op;
    logic [11:0] palette_address;
    logic [14:0] color_word;
    logic [31:0] texel_bits;
    logic [15:0] block_control;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic        bad_index;
    logic        last;
  } out_word_t;

  // fetched block handed from the palette fetch to the lanes and emitter
  typedef struct packed {
    logic [3:0][14:0] raw;
    logic [31:0]      texels;
    mode_t            mode;
    logic             bad;
  } blk_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] r;
    case (v)
      5'd0:  r = 8'h00;  5'd1:  r = 8'h08;  5'd2:  r = 8'h10;  5'd3:  r = 8'h19;
      5'd4:  r = 8'h21;  5'd5:  r = 8'h29;  5'd6:  r = 8'h31;  5'd7:  r = 8'h3A;
      5'd8:  r = 8'h42;  5'd9:  r = 8'h4A;  5'd10: r = 8'h52;  5'd11: r = 8'h5A;
      5'd12: r = 8'h63;  5'd13: r = 8'h6B;  5'd14: r = 8'h73;  5'd15: r = 8'h7B;
      5'd16: r = 8'h84;  5'd17: r = 8'h8C;  5'd18: r = 8'h94;  5'd19: r = 8'h9C;
      5'd20: r = 8'hA5;  5'd21: r = 8'hAD;  5'd22: r = 8'hB5;  5'd23: r = 8'hBD;
      5'd24: r = 8'hC5;  5'd25: r = 8'hCE;  5'd26: r = 8'hD6;  5'd27: r = 8'hDE;
      5'd28: r = 8'hE6;  5'd29: r = 8'hEF;  5'd30: r = 8'hF7;  5'd31: r = 8'hFF;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hdl/ctbd_fetch.sv]
// Palette store and block fetch: takes input words, writes palette entries,
// reads the four block colors as a low pair then a high pair. Depends on ctbd_pkg.
module ctbd_fetch (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ctbd_pkg::in_word_t  in_word,
  output logic                in_stall,
  input  logic [12:0]         pal_entries,
  input  logic                take,
  output logic                pend_valid,
  output ctbd_pkg::blk_t      pend_blk
);
  import ctbd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LO   = 3'b010,
    F_HI   = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic    pend_r, pend_nxt;

  logic [14:0] mem [PALETTE_DEPTH];
  logic [14:0] q0_r, q1_r;

  logic [PAL_AW-2:0] pair_r, in_pair, rd_pair;
  logic [PAL_AW-1:0] wr_addr;
  logic [13:0]       in_base;
  logic              acc, wr, dec;
  blk_t              blk_r;

  assign in_stall = (state_r != F_IDLE) || pend_r;
  assign acc      = in_valid && !in_stall;
  assign wr       = acc && (in_word.op == OP_PAL_WRITE);
  assign dec      = acc && (in_word.op == OP_DECODE);
  assign in_base  = in_word.block_control[13:0];
  assign in_pair  = (PAL_AW-1)'(in_base);
  assign wr_addr  = PAL_AW'(in_word.palette_address);
  assign rd_pair  = (state_r == F_IDLE) ? in_pair : pair_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= in_word.color_word;
    end
    q0_r <= mem[{rd_pair, 1'b0}];
    q1_r <= mem[{rd_pair, 1'b1}];
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r && !take;
    case (state_r)
      F_IDLE: if (dec) state_nxt = F_LO;
      F_LO:   state_nxt = F_HI;
      F_HI: begin
        state_nxt = F_IDLE;
        pend_nxt  = 1'b1;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec) begin
      pair_r       <= in_pair;
      blk_r.texels <= in_word.texel_bits;
      blk_r.mode   <= mode_t'(in_word.block_control[15:14]);
      blk_r.bad    <= {in_base, 1'b0} > {2'b00, pal_entries};
    end
    if (state_r == F_LO) begin
      blk_r.raw[0] <= q0_r;
      blk_r.raw[1] <= q1_r;
    end
    if (state_r == F_HI) begin
      blk_r.raw[2] <= q0_r;
      blk_r.raw[3] <= q1_r;
    end
  end

  assign pend_valid = pend_r;
  assign pend_blk   = blk_r;

endmodule

[hdl/ctbd_lane.sv]
// One color channel lane: expands the 5-bit channel of the four fetched colors
// and forms the midpoint and 5:3 / 3:5 blends. Depends on ctbd_pkg.
module ctbd_lane (
  input  logic [4:0]       c0_i,
  input  logic [4:0]       c1_i,
  input  logic [4:0]       c2_i,
  input  logic [4:0]       c3_i,
  input  ctbd_pkg::mode_t  mode_i,
  output logic [3:0][7:0]  ch_o
);
  import ctbd_pkg::*;

  logic [7:0]  e0, e1, e2, e3;
  logic [8:0]  sum11;
  logic [10:0] sum53, sum35;

  assign e0 = expand5(c0_i);
  assign e1 = expand5(c1_i);
  assign e2 = expand5(c2_i);
  assign e3 = expand5(c3_i);

  assign sum11 = 9'(e0) + 9'(e1);
  assign sum53 = 11'({e0, 2'b00}) + 11'(e0) + 11'({e1, 1'b0}) + 11'(e1);
  assign sum35 = 11'({e1, 2'b00}) + 11'(e1) + 11'({e0, 1'b0}) + 11'(e0);

  always_comb begin
    ch_o[0] = e0;
    ch_o[1] = e1;
    case (mode_i)
      MODE_DIRECT: begin
        ch_o[2] = e2;
        ch_o[3] = e3;
      end
      MODE_MID: begin
        ch_o[2] = sum11[8:1];
        ch_o[3] = e3;
      end
      MODE_FOUR: begin
        ch_o[2] = e2;
        ch_o[3] = e3;
      end
      default: begin
        ch_o[2] = sum53[10:3];
        ch_o[3] = sum35[10:3];
      end
    endcase
  end

endmodule

[hdl/ctbd_emit.sv]
// Pixel emitter: registers merged block colors, walks the sixteen texels into
// the output register and keeps the block column/row counter. Depends on ctbd_pkg.
module ctbd_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pend_valid,
  input  logic [3:0][31:0]     colors,
  input  logic [31:0]          texels,
  input  logic                 bad,
  input  logic [2:0]           width_log2,
  input  logic [2:0]           height_log2,
  output logic                 take,
  output logic                 out_valid,
  output ctbd_pkg::out_word_t  out_word,
  input  logic                 out_stall
);
  import ctbd_pkg::*;

  logic            busy_r, busy_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      col_r, col_nxt, row_r, row_nxt;
  logic [7:0]      col_inc, row_inc;
  logic [8:0]      hblocks, vblocks;
  logic            adv;

  logic [3:0][31:0] colors_r;
  logic [31:0]      texel_r;
  logic             bad_r;
  logic [7:0]       bx_r, by_r;
  out_word_t        out_word_r;

  assign adv  = busy_r && (!out_valid_r || !out_stall);
  assign take = pend_valid && (!busy_r || (adv && (cnt_r == 4'd15)));

  assign hblocks = 9'd2 << width_log2;
  assign vblocks = 9'd2 << height_log2;
  assign col_inc = col_r + 8'd1;
  assign row_inc = row_r + 8'd1;

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = cnt_r + 4'd1;
      if (cnt_r == 4'd15) busy_nxt = 1'b0;
    end
    if (take) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      col_nxt  = col_inc;
      if (({1'b0, col_inc} >= hblocks) || (col_inc == 8'd0)) begin
        col_nxt = 8'd0;
        row_nxt = row_inc;
        if ({1'b0, row_inc} >= vblocks) row_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.pixel_color <= colors_r[texel_r[1:0]];
      out_word_r.pixel_x     <= {bx_r, cnt_r[1:0]};
      out_word_r.pixel_y     <= {by_r, cnt_r[3:2]};
      out_word_r.bad_index   <= bad_r;
      out_word_r.last        <= (cnt_r == 4'd15);
    end
    if (take) begin
      colors_r <= colors;
      texel_r  <= texels;
      bad_r    <= bad;
      bx_r     <= col_r;
      by_r     <= row_r;
    end else if (adv) begin
      texel_r  <= {2'b00, texel_r[31:2]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[hdl/compressed_4x4_texel_block_decoder_core.sv]
// Top level of the 4x4 compressed texel block decoder: config registers,
// fetch, three channel lanes, color merge and pixel emitter. Depends on ctbd_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_word): a word with op = palette write
//   stores color_word at palette_address and yields nothing; a word with
//   op = decode yields sixteen pixel words, row-major, last set on the final one.
//   Output channel (out_valid/out_stall/out_word) carries one pixel per cycle
//   while out_stall is low. Config port (cfg_we/cfg_index/cfg_wdata) sets
//   width_log2, height_log2 and palette_entries; write only while the block is idle.
// Timing:
//   A decode word reads its four palette colors as a low pair then a high pair
//   through the two read ports of the palette store; the fetched block then waits
//   in the pending register until the emitter takes it, and each pixel passes
//   through the emitter's output register. The next block is fetched while the
//   current one drains. Palette writes are taken one per cycle while no block
//   is being fetched or waiting.
// Reset clears the config registers, block counter and all valid flags; palette
// contents are undefined until written. A stalled output holds its word and the
// pipeline fills, then raises in_stall.
module compressed_4x4_texel_block_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  ctbd_pkg::in_word_t            in_word,
  output logic                          in_stall,
  output logic                          out_valid,
  output ctbd_pkg::out_word_t           out_word,
  input  logic                          out_stall,
  input  logic                          cfg_we,
  input  logic [ctbd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ctbd_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ctbd_pkg::*;

  logic [2:0]  width_log2_r, height_log2_r;
  logic [12:0] entries_r;

  logic             pend_valid, take;
  blk_t             pend_blk;
  logic [2:0][3:0][7:0] lane_ch;
  logic [3:0][31:0] colors;
  logic             c3_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= 3'd0;
      height_log2_r <= 3'd0;
      entries_r     <= 13'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_LOG2:  width_log2_r  <= cfg_wdata[2:0];
        CFG_HEIGHT_LOG2: height_log2_r <= cfg_wdata[2:0];
        CFG_PAL_ENTRIES: entries_r     <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  ctbd_fetch u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .in_stall    (in_stall),
    .pal_entries (entries_r),
    .take        (take),
    .pend_valid  (pend_valid),
    .pend_blk    (pend_blk)
  );

  // lane 0 red, 1 green, 2 blue
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ctbd_lane u_lane (
      .c0_i   (pend_blk.raw[0][5*i +: 5]),
      .c1_i   (pend_blk.raw[1][5*i +: 5]),
      .c2_i   (pend_blk.raw[2][5*i +: 5]),
      .c3_i   (pend_blk.raw[3][5*i +: 5]),
      .mode_i (pend_blk.mode),
      .ch_o   (lane_ch[i])
    );
  end

  // merge: fourth color is transparent black unless it comes from a fourth entry or a blend
  assign c3_on = (pend_blk.mode == MODE_FOUR) || (pend_blk.mode == MODE_BLEND);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      colors[k] = {8'hFF, lane_ch[0][k], lane_ch[1][k], lane_ch[2][k]};
    end
    if (!c3_on) colors[3] = 32'h0;
  end

  ctbd_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .pend_valid  (pend_valid),
    .colors      (colors),
    .texels      (pend_blk.texels),
    .bad         (pend_blk.bad),
    .width_log2  (width_log2_r),
    .height_log2 (height_log2_r),
    .take        (take),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .out_stall   (out_stall)
  );

endmodule

[dv/tb_compressed_4x4_texel_block_decoder_core.sv]
// Testbench for compressed_4x4_texel_block_decoder_core: drives palette and block words with
// random gaps and output stalls, predicts every pixel word and checks it field by field.
// Depends on ctbd_pkg and the core RTL.
module tb_compressed_4x4_texel_block_decoder_core;
  import ctbd_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  logic      out_stall = 1'b0;
  logic      cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  compressed_4x4_texel_block_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mirror of the block state
  logic [14:0]  palette_mirror [PALETTE_DEPTH];
  int unsigned  blk_col = 0;
  int unsigned  blk_row = 0;
  int unsigned  width_cfg = 0;
  int unsigned  height_cfg = 0;
  int unsigned  entries_cfg = 0;

  out_word_t    expected_pixels [$];
  out_word_t    want;
  int unsigned  fail_count = 0;
  int unsigned  block_count = 0;
  int unsigned  pal_write_count = 0;
  int unsigned  setting_count = 0;
  int unsigned  pixel_count = 0;
  int           in_calm = 0;
  int           stall_left = 0;
  int           out_calm = 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // 5-bit channel to 8 bits, same values as the fixed expansion table
  function automatic logic [7:0] ch8(input logic [4:0] v);
    int unsigned t;
    t = (int'(v) * 255 + 15) / 31;
    return t[7:0];
  endfunction

  function automatic logic [31:0] argb_of(input logic [14:0] c);
    return {8'hFF, ch8(c[4:0]), ch8(c[9:5]), ch8(c[14:10])};
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input int unsigned wa, input int unsigned wb);
    logic [31:0] r;
    int unsigned s;
    r = 32'hFF00_0000;
    for (int sh = 0; sh < 24; sh += 8) begin
      s = (int'(a[sh +: 8]) * wa + int'(b[sh +: 8]) * wb) / (wa + wb);
      r[sh +: 8] = s[7:0];
    end
    return r;
  endfunction

  function automatic void predict_pixels(input in_word_t w);
    logic [31:0] col [4];
    logic [14:0] pair;
    logic [11:0] ai;
    mode_t       m;
    logic        bad;
    out_word_t   px;
    int unsigned hb;
    int unsigned vb;
    if (w.op == OP_PAL_WRITE) begin
      palette_mirror[w.palette_address] = w.color_word;
      pal_write_count++;
      return;
    end
    pair = {w.block_control[13:0], 1'b0};
    m    = mode_t'(w.block_control[15:14]);
    bad  = (pair > entries_cfg);
    for (int i = 0; i < 4; i++) begin
      ai = pair[11:0] + 12'(i);
      col[i] = argb_of(palette_mirror[ai]);
    end
    case (m)
      MODE_DIRECT: col[3] = '0;
      MODE_MID: begin
        col[2] = blend(col[0], col[1], 1, 1);
        col[3] = '0;
      end
      MODE_FOUR: ;
      default: begin
        col[2] = blend(col[0], col[1], 5, 3);
        col[3] = blend(col[0], col[1], 3, 5);
      end
    endcase
    for (int n = 0; n < 16; n++) begin
      px.pixel_color = col[w.texel_bits[2*n +: 2]];
      px.pixel_x     = 10'(blk_col * 4 + n % 4);
      px.pixel_y     = 10'(blk_row * 4 + n / 4);
      px.bad_index   = bad;
      px.last        = (n == 15);
      expected_pixels.push_back(px);
    end
    hb = 2 << width_cfg;
    vb = 2 << height_cfg;
    blk_col = (blk_col + 1) & 8'hFF;
    if (blk_col >= hb || blk_col == 0) begin
      blk_col = 0;
      blk_row = (blk_row + 1) & 8'hFF;
      if (blk_row >= vb) blk_row = 0;
    end
    block_count++;
  endfunction

  // output side: random stalls with calm stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_calm > 0) begin
        out_calm <= out_calm - 1;
      end else begin
        stall_left <= draw_gap();
        out_calm   <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pixel_count++;
      if (expected_pixels.size() == 0) begin
        $error("pixel word with nothing expected: %h", out_word);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_word.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, got %h", want.pixel_color, out_word.pixel_color);
          fail_count++;
        end
        if (out_word.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_word.pixel_x);
          fail_count++;
        end
        if (out_word.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_word.pixel_y);
          fail_count++;
        end
        if (out_word.bad_index !== want.bad_index) begin
          $error("bad_index: expected %b, got %b", want.bad_index, out_word.bad_index);
          fail_count++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_word.last);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      gap = draw_gap();
      if ($urandom_range(0, 19) == 0) in_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predict_pixels(w);
  endtask

  task automatic pal_write(input logic [11:0] addr, input logic [14:0] color);
    in_word_t w;
    w.op              = OP_PAL_WRITE;
    w.palette_address = addr;
    w.color_word      = color;
    w.texel_bits      = $urandom;
    w.block_control   = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_block(input logic [31:0] texels, input mode_t m, input logic [13:0] base);
    in_word_t w;
    w.op              = OP_DECODE;
    w.palette_address = 12'($urandom);
    w.color_word      = 15'($urandom);
    w.texel_bits      = texels;
    w.block_control   = {m, base};
    send_word(w);
  endtask

  // pairs stay on preloaded entries; upper base bits alias through the store wrap
  task automatic random_block();
    logic [13:0] base;
    int unsigned idx;
    idx = $urandom_range(0, 16);
    base[10:0]  = (idx < 15) ? 11'(idx) : 11'(2046 + idx - 15);
    base[13:11] = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom);
    send_block($urandom, mode_t'($urandom_range(0, 3)), base);
  endtask

  // drain results, then cover a palette write still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned p);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH_LOG2;
    cfg_wdata <= CFG_DW'(w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT_LOG2;
    cfg_wdata <= CFG_DW'(h);
    @(posedge clk);
    cfg_index <= CFG_PAL_ENTRIES;
    cfg_wdata <= CFG_DW'(p);
    @(posedge clk);
    cfg_we      <= 1'b0;
    width_cfg   = w;
    height_cfg  = h;
    entries_cfg = p;
    setting_count++;
  endtask

  // low entries and the last two pairs, so no decode reads an unwritten color
  task automatic test_palette_preload();
    for (int a = 0; a < 32; a++) pal_write(12'(a), 15'($urandom));
    for (int a = PALETTE_DEPTH - 4; a < PALETTE_DEPTH; a++) pal_write(12'(a), 15'($urandom));
  endtask

  task automatic test_directed_cases();
    set_config(0, 0, 4096);
    pal_write(12'd0, 15'h0000);
    pal_write(12'd1, 15'h7FFF);
    pal_write(12'd2, 15'h7C1F);
    pal_write(12'd4095, 15'h03E0);
    send_block(32'hE4E4_E4E4, MODE_DIRECT, 14'd0);
    send_block(32'hE4E4_E4E4, MODE_MID, 14'd0);
    send_block(32'hE4E4_E4E4, MODE_FOUR, 14'd0);
    send_block(32'hE4E4_E4E4, MODE_BLEND, 14'd0);
    send_block(32'h0000_0000, MODE_BLEND, 14'd1);
    send_block(32'hFFFF_FFFF, MODE_BLEND, 14'd1);
    send_block(32'hAAAA_AAAA, MODE_FOUR, 14'd7);
    send_block(32'h5555_5555, MODE_MID, 14'd9);
    // pair base wraps past the end of the store, flagged bad
    send_block(32'h1B1B_1B1B, MODE_FOUR, 14'h3FFF);
    send_block(32'hE4E4_E4E4, MODE_FOUR, 14'd2047);
    // index exactly at the palette length is fine, one pair beyond is bad
    send_block(32'hE4E4_E4E4, MODE_FOUR, 14'd2048);
    send_block(32'hE4E4_E4E4, MODE_FOUR, 14'd2049);
  endtask

  // columns and rows walk a 4 by 4 block grid and wrap
  task automatic test_counter_walk();
    set_config(1, 1, 8191);
    for (int i = 0; i < 20; i++) random_block();
  endtask

  // counter left beyond smaller bounds is used once, then wraps
  task automatic test_counter_shrink();
    set_config(1, 1, 4096);
    for (int i = 0; i < 7; i++) random_block();
    set_config(0, 0, 100);
    for (int i = 0; i < 4; i++) random_block();
  endtask

  task automatic test_random_mix();
    int unsigned p;
    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 3))
        0: p = 0;
        1: p = 8191;
        2: p = 4096;
        default: p = $urandom_range(0, 8191);
      endcase
      set_config($urandom_range(0, 7), $urandom_range(0, 7), p);
      for (int i = 0; i < 28; i++) begin
        if ($urandom_range(0, 9) < 3) pal_write(12'($urandom), 15'($urandom));
        else random_block();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_palette_preload();
    test_directed_cases();
    test_counter_walk();
    test_counter_shrink();
    test_random_mix();
    wait_idle();
    $display("Covered %0d blocks (%0d pixels checked) and %0d palette writes",
             block_count, pixel_count, pal_write_count);
    $display("across %0d register settings, all four modes and bad palette indexes",
             setting_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
